FILE: hw/rtl/lkv_cache_pkg.sv
// ----------------------------------------------------------------------------
// lkv_cache_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_cache_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // request kinds
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);
    localparam logic signed [DATA_W-1:0] SET_VALUE  = '0;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lkv_pick_first.sv
// ----------------------------------------------------------------------------
// lkv_pick_first
// Priority encoder: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_pick_first #(
    parameter int N = 16
) (
    input  wire logic [N-1:0]         vec,
    output logic                      found,
    output logic [$clog2(N)-1:0]      idx
);

    localparam int IDX_W = $clog2(N);

    always_comb
    begin
        found = |vec;
        idx   = '0;
        // scan downward so the lowest set bit wins
        for (int i = N - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lkv_entry_array.sv
// ----------------------------------------------------------------------------
// lkv_entry_array
// Entry storage, parallel key match, recency ranks and replacement choice.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_entry_array
    import lkv_cache_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire logic                              req_type,
    input  wire logic signed [DATA_W-1:0]          key,
    input  wire logic signed [DATA_W-1:0]          value,
    input  wire logic [$clog2(ENTRIES+1)-1:0]      eff_cap,
    output logic                                   hit,
    output logic signed [DATA_W-1:0]               read_value
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic signed [DATA_W-1:0] keys_reg   [ENTRIES];
    logic signed [DATA_W-1:0] keys_next  [ENTRIES];
    logic signed [DATA_W-1:0] values_reg [ENTRIES];
    logic signed [DATA_W-1:0] values_next[ENTRIES];
    logic [IDX_W-1:0]         rank_reg   [ENTRIES];
    logic [IDX_W-1:0]         rank_next  [ENTRIES];
    logic [ENTRIES-1:0]       valid_reg;
    logic [ENTRIES-1:0]       valid_next;
    logic [CNT_W-1:0]         used_reg;
    logic [CNT_W-1:0]         used_next;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic               free_found;
    logic               victim_found;
    logic [CNT_W-1:0]   last_rank;
    logic               is_set;
    logic               has_room;
    logic               fill;
    logic               upd;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   limit;

    always_comb
    begin
        last_rank = used_reg - CNT_W'(1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = valid_reg[i] && (keys_reg[i] == key);
            // valid ranks are distinct, so the least recent one holds used-1
            victim_vec[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == last_rank);
        end
    end

    lkv_pick_first #(.N(ENTRIES)) u_pick_hit (
        .vec   (match_vec),
        .found (hit),
        .idx   (hit_idx)
    );

    lkv_pick_first #(.N(ENTRIES)) u_pick_free (
        .vec   (~valid_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    lkv_pick_first #(.N(ENTRIES)) u_pick_victim (
        .vec   (victim_vec),
        .found (victim_found),
        .idx   (victim_idx)
    );

    always_comb
    begin
        is_set   = (req_type == REQ_SET);
        has_room = (used_reg < eff_cap) && free_found;
        fill     = is_set && !hit && has_room;
        upd      = step && (hit || fill || (is_set && victim_found));

        if (hit)
        begin
            slot  = hit_idx;
            limit = rank_reg[hit_idx];
        end
        else if (has_room)
        begin
            slot  = free_idx;
            limit = '0;
        end
        else
        begin
            slot  = victim_idx;
            limit = IDX_W'(last_rank);
        end

        if (is_set)
        begin
            read_value = SET_VALUE;
        end
        else if (hit)
        begin
            read_value = values_reg[hit_idx];
        end
        else
        begin
            read_value = MISS_VALUE;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            keys_next[i]   = keys_reg[i];
            values_next[i] = values_reg[i];
            rank_next[i]   = rank_reg[i];
            if (upd)
            begin
                if (IDX_W'(i) == slot)
                begin
                    rank_next[i] = '0;
                    if (is_set)
                    begin
                        values_next[i] = value;
                    end
                    if (is_set && !hit)
                    begin
                        keys_next[i] = key;
                    end
                end
                else if (valid_reg[i] && (fill || (rank_reg[i] < limit)))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
        if (upd && fill)
        begin
            valid_next[slot] = 1'b1;
            used_next        = used_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg   <= keys_next;
        values_reg <= values_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request (get or set) is captured in an input register, resolved against
// all ENTRIES entries combinationally (parallel key compare, recency rank
// update, fill or eviction choice) and its response lands in a result
// register. The block takes one transaction per clock while the result
// port is not stalled; a stall there holds the request in the input
// register until the result register is free again. Valid bits and ranks
// clear at reset, so no clearing pass is needed and requests are taken
// right after reset.
// The capacity register (0 acts as 1, values above ENTRIES act as ENTRIES)
// should be written only while no transaction is in flight.
`default_nettype none

module lru_key_value_cache_core
    import lkv_cache_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    req_t             req_reg;
    req_t             req_next;
    logic             req_valid_reg;
    logic             req_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic             advance;
    logic             accept;
    logic [CMP_W-1:0] cap_ext;
    logic [CNT_W-1:0] eff_cap;
    logic             hit;
    logic signed [DATA_W-1:0] read_value;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(cap_ext);
        end
    end

    // held transaction moves on when the result register is free or drains
    assign advance   = req_valid_reg && !(rsp_valid_reg && rsp_stall);
    assign req_stall = req_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    lkv_entry_array #(.ENTRIES(ENTRIES)) u_entries (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .req_type   (req_reg.req_type),
        .key        (req_reg.lookup_key),
        .value      (req_reg.write_value),
        .eff_cap    (eff_cap),
        .hit        (hit),
        .read_value (read_value)
    );

    always_comb
    begin
        cap_next       = cfg_we ? cfg_data : cap_reg;
        req_next       = accept ? req : req_reg;
        req_valid_next = accept || (req_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);
        rsp_next       = rsp_reg;
        if (advance)
        begin
            rsp_next.hit        = hit;
            rsp_next.read_value = read_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: sim/lru_key_value_cache_core_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core_tb
// Self-checking bench for the LRU key/value cache. Requests go in through the
// request channel under random idling and back pressure. A behavioral copy of
// the cache (keys, values, recency ranks, fill count, capacity) works out the
// response for each accepted transaction, and each response that comes back
// is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb
    import lkv_cache_pkg::*;
();

    localparam int ENTRIES     = 16;
    localparam int KEY_POOL_SZ = 40;
    localparam int QUIET_LIMIT = 2000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_data  = '0;

    lru_key_value_cache_core #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cache state as the block should hold it
    logic signed [DATA_W-1:0] slot_key [ENTRIES];
    logic signed [DATA_W-1:0] slot_val [ENTRIES];
    bit                       slot_live[ENTRIES];
    int unsigned              slot_rank[ENTRIES];
    int unsigned              live_count = 0;
    logic [CAP_W-1:0]         capacity_reg = CAP_RESET;

    rsp_t                     lookup_results_due[$];
    logic signed [DATA_W-1:0] key_pool[KEY_POOL_SZ];

    int  n_sent       = 0;
    int  n_checked    = 0;
    int  n_hits       = 0;
    int  n_fills      = 0;
    int  n_evictions  = 0;
    int  n_cap_writes = 0;
    int  mismatches   = 0;
    int  quiet_cycles = 0;

    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;
    int  rx_hold_cycles = 0;
    int  hold_left     = 0;
    int  burst_left    = 0;

    // ------------------------------------------------------------------------
    // behavioral cache
    // ------------------------------------------------------------------------
    function automatic void make_newest(int s, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i != s && slot_live[i] && slot_rank[i] < limit)
                slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    function automatic rsp_t resolve_request(req_t r);
        rsp_t        res;
        int          found;
        int          slot;
        int          victim;
        int unsigned top_rank;
        int unsigned cap;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (found < 0 && slot_live[i] && slot_key[i] == r.lookup_key)
                found = i;
        end
        if (r.req_type == REQ_GET)
        begin
            if (found >= 0)
            begin
                res.hit        = 1'b1;
                res.read_value = slot_val[found];
                make_newest(found, slot_rank[found]);
            end
            else
            begin
                res.hit        = 1'b0;
                res.read_value = MISS_VALUE;
            end
            return res;
        end
        res.read_value = SET_VALUE;
        if (found >= 0)
        begin
            res.hit         = 1'b1;
            slot_val[found] = r.write_value;
            make_newest(found, slot_rank[found]);
            return res;
        end
        res.hit = 1'b0;
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
        slot = -1;
        if (live_count < cap)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && !slot_live[i])
                    slot = i;
            end
        end
        if (slot >= 0)
        begin
            slot_key[slot] = r.lookup_key;
            slot_val[slot] = r.write_value;
            make_newest(slot, 32'hFFFF_FFFF);
            slot_live[slot] = 1'b1;
            live_count++;
            n_fills++;
        end
        else
        begin
            // least recent is the live entry with the highest rank, lowest index on a tie
            victim   = -1;
            top_rank = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_live[i] && (victim < 0 || slot_rank[i] > top_rank))
                begin
                    victim   = i;
                    top_rank = slot_rank[i];
                end
            end
            if (victim >= 0)
            begin
                slot_key[victim] = r.lookup_key;
                slot_val[victim] = r.write_value;
                make_newest(victim, top_rank);
                n_evictions++;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    function automatic req_t make_req(logic kind, logic signed [DATA_W-1:0] k,
                                      logic signed [DATA_W-1:0] v);
        req_t r;
        r.req_type    = kind;
        r.lookup_key  = k;
        r.write_value = v;
        return r;
    endfunction

    // mostly keys from a small pool so hits and evictions happen often
    function automatic req_t random_req(int pool);
        req_t r;
        r.req_type = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8)
            r.lookup_key = key_pool[$urandom_range(0, pool - 1)];
        else
            r.lookup_key = $urandom;
        r.write_value = $urandom;
        return r;
    endfunction

    task automatic send_req(req_t r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        lookup_results_due.push_back(resolve_request(r));
        n_sent++;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (lookup_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we       <= 1'b0;
        capacity_reg  = c;
        n_cap_writes++;
    endtask

    // ------------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------------
    function automatic void check_response(rsp_t got);
        rsp_t want;
        if (lookup_results_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: response with none due: hit=%0b read_value=%0d",
                         got.hit, got.read_value);
        end
        else
        begin
            want = lookup_results_due.pop_front();
            n_checked++;
            if (want.hit)
                n_hits++;
            if (got.hit !== want.hit)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d hit: expected %0b got %0b",
                             n_checked, want.hit, got.hit);
            end
            if (got.read_value !== want.read_value)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d read_value: expected %0d got %0d",
                             n_checked, want.read_value, got.read_value);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (rx_hold_cycles != 0)
            begin
                hold_left      = rx_hold_cycles - 1;
                rx_hold_cycles = 0;
                rsp_stall     <= 1'b1;
            end
            else if (burst_left != 0)
            begin
                burst_left--;
                rsp_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(0, 2);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // cycles in which no transaction moves on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
        $display("lru_key_value_cache_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_corners();
        send_req(make_req(REQ_GET, 32'h0000_0000, 32'h1234_5678));  // empty cache
        send_req(make_req(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF));
        send_req(make_req(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000));
        send_req(make_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_req(make_req(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF));
        // stored value equals the miss marker, only hit tells them apart
        send_req(make_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));
        send_req(make_req(REQ_SET, 32'h8000_0000, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'h8000_0000, 32'hAAAA_5555));
        send_req(make_req(REQ_GET, 32'h7FFF_FFFE, 32'h0000_0000));
        send_req(make_req(REQ_SET, 32'h0000_0000, 32'h5A5A_5A5A));
        send_req(make_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));
    endtask

    task automatic test_capacity_limits();
        // shrink below the live count: nothing dropped, set misses replace lru
        set_capacity(1);
        send_req(make_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000));
        send_req(make_req(REQ_SET, 32'h0BAD_F00D, 32'h1111_1111));
        send_req(make_req(REQ_GET, 32'h0BAD_F00D, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'h8000_0000, 32'h0000_0000));
        // zero acts as one
        set_capacity(0);
        send_req(make_req(REQ_SET, 32'h0C0F_FEE0, 32'h2222_2222));
        send_req(make_req(REQ_GET, 32'h0BAD_F00D, 32'h0000_0000));
        // above ENTRIES saturates
        set_capacity(31);
        send_req(make_req(REQ_SET, 32'h0000_0001, 32'h0000_0003));
        send_req(make_req(REQ_GET, 32'h0000_0001, 32'h0000_0000));
    endtask

    task automatic test_random_traffic();
        int caps[9];
        int cap;
        int pool;
        caps    = '{16, 4, 0, 31, 8, 2, 1, 0, 12};
        caps[7] = $urandom_range(0, 31);
        for (int p = 0; p < 9; p++)
        begin
            set_capacity(CAP_W'(caps[p]));
            cap  = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
            pool = cap + 1 + $urandom_range(0, 8);
            if (pool > KEY_POOL_SZ)
                pool = KEY_POOL_SZ;
            for (int n = 0; n < 160; n++)
            begin
                if (n % 40 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 2) != 0);
                    rx_idle_on = ($urandom_range(0, 2) != 0);
                end
                send_req(random_req(pool));
            end
        end
    endtask

    task automatic test_back_pressure();
        set_capacity(6);
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 120;
        repeat (60) send_req(random_req(10));
    endtask

    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (3)
        begin
            repeat (20) send_req(random_req(12));
            wait_drained();
        end
    endtask

    task automatic test_steady_tail();
        set_capacity(16);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (250) send_req(random_req(20));
    endtask

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_live[i] = 1'b0;
            slot_rank[i] = 0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < KEY_POOL_SZ; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < KEY_POOL_SZ; i++)
        begin
            int j;
            logic signed [DATA_W-1:0] t;
            j           = $urandom_range(0, KEY_POOL_SZ - 1);
            t           = key_pool[i];
            key_pool[i] = key_pool[j];
            key_pool[j] = t;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_capacity_limits();
        test_random_traffic();
        test_back_pressure();
        test_drain_pause();
        test_steady_tail();
        wait_drained();

        $display("covered %0d requests and %0d responses (%0d hits), %0d mismatches",
                 n_sent, n_checked, n_hits, mismatches);
        $display("%0d fills and %0d evictions across %0d capacity writes",
                 n_fills, n_evictions, n_cap_writes);
        if (mismatches == 0 && lookup_results_due.size() == 0)
            $display("lru_key_value_cache_core test passed");
        else
            $display("lru_key_value_cache_core test failed");
        $finish;
    end

endmodule
